FILE: sv/assert_macros.svh
// assertion macros used by the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_HOLDS(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define ASSERT_NEXT(lbl, clk, rst, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define ASSERT_HOLDS(lbl, clk, rst, prop, msg)
`define ASSERT_NEXT(lbl, clk, rst, pre, post, msg)
`endif
`endif

FILE: sv/hpf4_pkg.sv
// constants and register codes for the fourth-order high-pass filter
package hpf4_pkg;

  localparam int COEF_W    = 32;
  localparam int NUM_COEF  = 7;
  localparam int CFG_IDX_W = 3;
  localparam int ACC_W     = 64;
  localparam int FRAC_BITS = 27;
  localparam int HIST_FRAC = 8;

  localparam logic [CFG_IDX_W-1:0] REG_A0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_A1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_A2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_B1 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_B2 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_B3 = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_B4 = 3'd6;

  localparam logic CMD_FILTER = 1'b0;
  localparam logic CMD_CLEAR  = 1'b1;

endpackage

FILE: sv/hpf4_round.sv
// round half up and saturate of the fixed-point accumulator
module hpf4_round #(
  parameter int SHIFT = 27,
  parameter int OUT_W = 24
) (
  input  logic signed [hpf4_pkg::ACC_W-1:0] acc,
  output logic signed [OUT_W-1:0]           res
);

  localparam int AW = hpf4_pkg::ACC_W;
  localparam logic signed [AW-1:0] HALF = AW'(64'd1 << (SHIFT - 1));
  localparam logic signed [AW-1:0] MAXV = AW'((64'd1 << (OUT_W - 1)) - 64'd1);
  localparam logic signed [AW-1:0] MINV = ~MAXV;

  logic signed [AW-1:0] biased;
  logic signed [AW-1:0] shifted;

  assign biased  = acc + HALF;
  assign shifted = biased >>> SHIFT;

  always_comb begin
    if (shifted > MAXV) begin
      res = MAXV[OUT_W-1:0];
    end else if (shifted < MINV) begin
      res = MINV[OUT_W-1:0];
    end else begin
      res = shifted[OUT_W-1:0];
    end
  end

endmodule

FILE: sv/fourth_order_highpass_iir_top.sv
// top level of the multichannel fourth-order high-pass iir filter
//
// samples enter on the sample channel (sample_valid, sample_stall) with cmd,
// channel and sample_in; results leave on the result channel (result_valid,
// result_stall) with channel_out and sample_out. coefficients are written on
// the cfg port (cfg_we, cfg_index, cfg_data); the user must write them only
// while the block is idle, as the block itself does not enforce it.
// one request per cycle is taken while a channel recurs no sooner than five
// requests apart and the receiver does not stall; a request whose channel
// is still in the four-stage read-modify-write path on the history memory
// waits until it has left. a clear request waits until the pipeline has
// drained, then drops all per-channel valid bits at once and gives no result.
// a request naming a channel at or beyond CHANNELS is taken and dropped.
// reset clears the coefficients, valid bits and pipeline; the history memory
// needs no clearing since invalid channels read as zero.
// when the receiver stalls, the result register holds and the stages behind
// it close up their gaps before the sample side is stalled.
module fourth_order_highpass_iir_top #(
  parameter int CHANNELS    = 8,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_we,
  input  logic [hpf4_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [hpf4_pkg::COEF_W-1:0]            cfg_data,
  input  logic                                   sample_valid,
  output logic                                   sample_stall,
  input  logic                                   cmd,
  input  logic [2:0]                             channel,
  input  logic signed [SAMPLE_BITS-1:0]          sample_in,
  output logic                                   result_valid,
  input  logic                                   result_stall,
  output logic [2:0]                             channel_out,
  output logic signed [SAMPLE_BITS-1:0]          sample_out
);

  `include "assert_macros.svh"

  localparam int SB  = SAMPLE_BITS;
  localparam int HB  = SAMPLE_BITS + hpf4_pkg::HIST_FRAC;
  localparam int CW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int AW  = hpf4_pkg::ACC_W;
  localparam int PIW = hpf4_pkg::COEF_W + SB + 1;
  localparam int PFW = hpf4_pkg::COEF_W + HB;

  typedef struct packed {
    logic [3:0][SB-1:0] x;
    logic [3:0][HB-1:0] y;
  } row_t;

  logic signed [hpf4_pkg::COEF_W-1:0] coef [hpf4_pkg::NUM_COEF];

  row_t mem [CHANNELS];
  row_t rd_row;
  logic [CHANNELS-1:0] hv;

  // pipeline stages
  logic               s1_valid, s2_valid, s3_valid, s4_valid;
  logic [2:0]         s1_ch, s2_ch, s3_ch, s4_ch;
  logic [CW-1:0]      s1_addr, s2_addr, s3_addr, s4_addr;
  logic signed [SB-1:0] s1_x;
  logic               s1_hv;
  logic [3:0][SB-1:0] s2_xrow, s3_xrow, s4_xrow;
  logic [2:0][HB-1:0] s2_yrow, s3_yrow, s4_yrow;
  logic signed [AW-1:0] s2_t [hpf4_pkg::NUM_COEF];
  logic signed [AW-1:0] s3_in_sum, s3_fb_sum;
  logic signed [AW-1:0] s4_acc;

  logic out_free, free1, free2, free3, free4;
  logic mv1, mv2, mv3, mv4;
  logic busy, hit, in_range, go, enter, clear_go;
  logic [CW-1:0] addr_in;

  logic [3:0][SB-1:0] xh;
  logic [3:0][HB-1:0] yh;
  logic [3:0][SB-1:0] xrow_next;
  logic [2:0][HB-1:0] yrow_next;
  logic signed [SB:0]   in_outer, in_inner;
  logic signed [PIW-1:0] p_in [3];
  logic signed [PFW-1:0] p_fb [4];
  logic signed [AW-1:0]  t_next [hpf4_pkg::NUM_COEF];
  logic signed [AW-1:0]  fb_wide [4];

  logic signed [HB-1:0] y_hist;
  logic signed [SB-1:0] y_out;
  row_t wr_row;

  // handshake and hazards
  assign out_free = !result_valid || !result_stall;
  assign free4    = !s4_valid || out_free;
  assign free3    = !s3_valid || free4;
  assign free2    = !s2_valid || free3;
  assign free1    = !s1_valid || free2;
  assign mv4      = s4_valid && out_free;
  assign mv3      = s3_valid && free4;
  assign mv2      = s2_valid && free3;
  assign mv1      = s1_valid && free2;

  assign addr_in  = CW'(channel);
  assign in_range = int'(channel) < CHANNELS;
  assign busy     = s1_valid || s2_valid || s3_valid || s4_valid;
  assign hit      = (s1_valid && s1_addr == addr_in) || (s2_valid && s2_addr == addr_in) ||
                    (s3_valid && s3_addr == addr_in) || (s4_valid && s4_addr == addr_in);

  assign sample_stall = !free1 || ((cmd == hpf4_pkg::CMD_CLEAR) ? busy : hit);
  assign go       = sample_valid && !sample_stall;
  assign enter    = go && cmd == hpf4_pkg::CMD_FILTER && in_range;
  assign clear_go = go && cmd == hpf4_pkg::CMD_CLEAR;

  // coefficient registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < hpf4_pkg::NUM_COEF; i++) begin
        coef[i] <= '0;
      end
    end else if (cfg_we && int'(cfg_index) < hpf4_pkg::NUM_COEF) begin
      coef[cfg_index] <= cfg_data;
    end
  end

  // history memory, one row per channel
  always_ff @(posedge clk) begin
    if (mv4) begin
      mem[s4_addr] <= wr_row;
    end
    if (enter) begin
      rd_row <= mem[addr_in];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hv <= '0;
    end else if (clear_go) begin
      hv <= '0;
    end else if (mv4) begin
      hv[s4_addr] <= 1'b1;
    end
  end

  // products from the fetched history
  always_comb begin
    xh = s1_hv ? rd_row.x : '0;
    yh = s1_hv ? rd_row.y : '0;
    xrow_next = {xh[2], xh[1], xh[0], s1_x};
    yrow_next = {yh[2], yh[1], yh[0]};
    in_outer  = (SB+1)'(s1_x) + (SB+1)'($signed(xh[3]));
    in_inner  = (SB+1)'($signed(xh[0])) + (SB+1)'($signed(xh[2]));
    p_in[0]   = coef[hpf4_pkg::REG_A0] * in_outer;
    p_in[1]   = coef[hpf4_pkg::REG_A1] * in_inner;
    p_in[2]   = coef[hpf4_pkg::REG_A2] * $signed(xh[1]);
    p_fb[0]   = coef[hpf4_pkg::REG_B1] * $signed(yh[0]);
    p_fb[1]   = coef[hpf4_pkg::REG_B2] * $signed(yh[1]);
    p_fb[2]   = coef[hpf4_pkg::REG_B3] * $signed(yh[2]);
    p_fb[3]   = coef[hpf4_pkg::REG_B4] * $signed(yh[3]);
    for (int i = 0; i < 3; i++) begin
      t_next[i] = AW'(p_in[i]);
    end
    for (int i = 0; i < 4; i++) begin
      fb_wide[i]  = AW'(p_fb[i]);
      t_next[3+i] = fb_wide[i] >>> hpf4_pkg::HIST_FRAC;
    end
  end

  // stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      s2_valid     <= 1'b0;
      s3_valid     <= 1'b0;
      s4_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      s1_valid     <= enter || (s1_valid && !mv1);
      s2_valid     <= mv1 || (s2_valid && !mv2);
      s3_valid     <= mv2 || (s3_valid && !mv3);
      s4_valid     <= mv3 || (s4_valid && !mv4);
      result_valid <= mv4 || (result_valid && result_stall);
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (enter) begin
      s1_ch   <= channel;
      s1_addr <= addr_in;
      s1_x    <= sample_in;
      s1_hv   <= hv[addr_in];
    end
    if (mv1) begin
      s2_ch   <= s1_ch;
      s2_addr <= s1_addr;
      s2_xrow <= xrow_next;
      s2_yrow <= yrow_next;
      for (int i = 0; i < hpf4_pkg::NUM_COEF; i++) begin
        s2_t[i] <= t_next[i];
      end
    end
    if (mv2) begin
      s3_ch     <= s2_ch;
      s3_addr   <= s2_addr;
      s3_xrow   <= s2_xrow;
      s3_yrow   <= s2_yrow;
      s3_in_sum <= s2_t[0] + s2_t[1] + s2_t[2];
      s3_fb_sum <= s2_t[3] + s2_t[4] + s2_t[5] + s2_t[6];
    end
    if (mv3) begin
      s4_ch   <= s3_ch;
      s4_addr <= s3_addr;
      s4_xrow <= s3_xrow;
      s4_yrow <= s3_yrow;
      s4_acc  <= s3_in_sum - s3_fb_sum;
    end
    if (mv4) begin
      channel_out <= s4_ch;
      sample_out  <= y_out;
    end
  end

  hpf4_round #(
    .SHIFT(hpf4_pkg::FRAC_BITS - hpf4_pkg::HIST_FRAC),
    .OUT_W(HB)
  ) u_round_hist (
    .acc(s4_acc),
    .res(y_hist)
  );

  hpf4_round #(
    .SHIFT(hpf4_pkg::FRAC_BITS),
    .OUT_W(SB)
  ) u_round_out (
    .acc(s4_acc),
    .res(y_out)
  );

  assign wr_row.x = s4_xrow;
  assign wr_row.y = {s4_yrow, y_hist};

  `ASSERT_HOLDS(a_clear_drained, clk, rst, !clear_go || !busy, "clear taken with pipeline busy")
  `ASSERT_NEXT(a_clear_drops, clk, rst, clear_go, hv == '0, "valid bits survive a clear")
  `ASSERT_HOLDS(a_no_overlap, clk, rst, !(s1_valid && s2_valid && s1_addr == s2_addr), "same channel twice in flight")
  `ASSERT_NEXT(a_result_shown, clk, rst, mv4, result_valid && hv[$past(s4_addr)], "finished sample lost")

endmodule

FILE: verif/hpf4_sample_checker.sv
// checker: predicts each filtered sample of the high-pass filter and compares the results
module hpf4_sample_checker #(
  parameter int CHANNELS    = 8,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [hpf4_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [hpf4_pkg::COEF_W-1:0]          cfg_data,
  input  logic                                 sample_valid,
  input  logic                                 sample_stall,
  input  logic                                 cmd,
  input  logic [2:0]                           channel,
  input  logic signed [SAMPLE_BITS-1:0]        sample_in,
  input  logic                                 result_valid,
  input  logic                                 result_stall,
  input  logic [2:0]                           channel_out,
  input  logic signed [SAMPLE_BITS-1:0]        sample_out,
  output int                                   failures,
  output int                                   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HIST_W = SAMPLE_BITS + hpf4_pkg::HIST_FRAC;

  typedef struct packed {
    logic [2:0]             ch;
    logic [SAMPLE_BITS-1:0] smp;
  } filtered_t;

  logic signed [63:0]            coefs [hpf4_pkg::NUM_COEF];
  logic signed [SAMPLE_BITS-1:0] x_hist [CHANNELS][4];
  logic signed [HIST_W-1:0]      y_hist [CHANNELS][4];
  logic [CHANNELS-1:0]           hist_valid;
  filtered_t                     expected_samples [$];

  function automatic logic signed [63:0] round_sat(input logic signed [63:0] v,
                                                   input int shift, input int bits);
    logic signed [63:0] r;
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    r  = (v + (64'sd1 <<< (shift - 1))) >>> shift;
    hi = (64'sd1 <<< (bits - 1)) - 64'sd1;
    lo = ~hi;
    if (r > hi) return hi;
    if (r < lo) return lo;
    return r;
  endfunction

  task automatic predict_filter(input logic [2:0] ch, input logic signed [SAMPLE_BITS-1:0] x);
    logic signed [63:0] xh [4];
    logic signed [63:0] yh [4];
    logic signed [63:0] xs;
    logic signed [63:0] acc;
    logic signed [63:0] y_new;
    logic signed [63:0] s_new;
    int k;
    for (k = 0; k < 4; k++) begin
      if (hist_valid[ch]) begin
        xh[k] = 64'(x_hist[ch][k]);
        yh[k] = 64'(y_hist[ch][k]);
      end else begin
        xh[k] = '0;
        yh[k] = '0;
      end
    end
    xs = 64'(x);
    acc = coefs[hpf4_pkg::REG_A0] * (xs + xh[3]);
    acc += coefs[hpf4_pkg::REG_A1] * (xh[0] + xh[2]);
    acc += coefs[hpf4_pkg::REG_A2] * xh[1];
    acc -= (coefs[hpf4_pkg::REG_B1] * yh[0]) >>> hpf4_pkg::HIST_FRAC;
    acc -= (coefs[hpf4_pkg::REG_B2] * yh[1]) >>> hpf4_pkg::HIST_FRAC;
    acc -= (coefs[hpf4_pkg::REG_B3] * yh[2]) >>> hpf4_pkg::HIST_FRAC;
    acc -= (coefs[hpf4_pkg::REG_B4] * yh[3]) >>> hpf4_pkg::HIST_FRAC;
    y_new = round_sat(acc, hpf4_pkg::FRAC_BITS - hpf4_pkg::HIST_FRAC, HIST_W);
    s_new = round_sat(acc, hpf4_pkg::FRAC_BITS, SAMPLE_BITS);
    for (k = 3; k > 0; k--) begin
      x_hist[ch][k] = xh[k-1][SAMPLE_BITS-1:0];
      y_hist[ch][k] = yh[k-1][HIST_W-1:0];
    end
    x_hist[ch][0]  = x;
    y_hist[ch][0]  = y_new[HIST_W-1:0];
    hist_valid[ch] = 1'b1;
    expected_samples.push_back('{ch: ch, smp: s_new[SAMPLE_BITS-1:0]});
  endtask

  task automatic check_result();
    filtered_t want;
    if (expected_samples.size() == 0) begin
      $error("result on channel %0d with no request pending", channel_out);
      failures++;
    end else begin
      want = expected_samples.pop_front();
      if (channel_out !== want.ch) begin
        $error("channel_out mismatch: expected %0d, got %0d", want.ch, channel_out);
        failures++;
      end
      if (sample_out !== want.smp) begin
        $error("sample_out mismatch: expected %0d, got %0d", $signed(want.smp), sample_out);
        failures++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      foreach (coefs[i]) coefs[i] = '0;
      hist_valid = '0;
      expected_samples.delete();
      failures = 0;
      pending  = 0;
    end else begin
      if (result_valid && !result_stall) check_result();
      if (cfg_we && cfg_index < hpf4_pkg::NUM_COEF) coefs[cfg_index] = 64'($signed(cfg_data));
      if (sample_valid && !sample_stall) begin
        if (cmd == hpf4_pkg::CMD_CLEAR) hist_valid = '0;
        else if (channel < CHANNELS) predict_filter(channel, sample_in);
      end
      pending = expected_samples.size();
    end
  end

endmodule

FILE: verif/tb_fourth_order_highpass_iir_top.sv
// testbench top: request stimulus, coefficient phases and verdict for the high-pass filter
module tb_fourth_order_highpass_iir_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CH           = 8;
  localparam int SB           = 24;
  localparam int DRAIN_CYCLES = 8;
  localparam int COEF_MAX     = 32'h7FFF_FFFF;
  localparam int COEF_MIN     = 32'h8000_0000;
  localparam logic [SB-1:0] SAMPLE_MAX = {1'b0, {(SB-1){1'b1}}};
  localparam logic [SB-1:0] SAMPLE_MIN = {1'b1, {(SB-1){1'b0}}};

  logic                           clk;
  logic                           rst;
  logic                           cfg_we;
  logic [hpf4_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [hpf4_pkg::COEF_W-1:0]    cfg_data;
  logic                           sample_valid;
  logic                           sample_stall;
  logic                           cmd;
  logic [2:0]                     channel;
  logic signed [SB-1:0]           sample_in;
  logic                           result_valid;
  logic                           result_stall;
  logic [2:0]                     channel_out;
  logic signed [SB-1:0]           sample_out;

  int         failures;
  int         pending;
  int         send_idle_pct;
  int         recv_stall_pct;
  int         hold_left;
  logic [2:0] last_ch;

  fourth_order_highpass_iir_top #(
    .CHANNELS    (CH),
    .SAMPLE_BITS (SB)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .cmd          (cmd),
    .channel      (channel),
    .sample_in    (sample_in),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .channel_out  (channel_out),
    .sample_out   (sample_out)
  );

  hpf4_sample_checker #(
    .CHANNELS    (CH),
    .SAMPLE_BITS (SB)
  ) u_checker (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .cmd          (cmd),
    .channel      (channel),
    .sample_in    (sample_in),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .channel_out  (channel_out),
    .sample_out   (sample_out),
    .failures     (failures),
    .pending      (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("CHECKS FAILED");
    $finish;
  end

  // receiver: long hold-off when asked, otherwise random stalls
  initial begin
    result_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        result_stall <= 1'b1;
        hold_left--;
      end else begin
        result_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  task automatic send_request(input logic c, input logic [2:0] ch, input logic [SB-1:0] s);
    while ($urandom_range(99) < send_idle_pct) begin
      sample_valid <= 1'b0;
      @(negedge clk);
    end
    sample_valid <= 1'b1;
    cmd          <= c;
    channel      <= ch;
    sample_in    <= s;
    last_ch      = ch;
    do @(posedge clk); while (sample_stall);
    @(negedge clk);
  endtask

  task automatic random_request();
    logic           c;
    logic [2:0]     ch;
    logic [SB-1:0]  s;
    int             small_val;
    c  = ($urandom_range(99) < 3) ? hpf4_pkg::CMD_CLEAR : hpf4_pkg::CMD_FILTER;
    ch = ($urandom_range(99) < 30) ? last_ch : 3'($urandom);
    small_val = int'($urandom_range(2000)) - 1000;
    case ($urandom_range(9))
      0:       s = SAMPLE_MAX;
      1:       s = SAMPLE_MIN;
      2:       s = SB'(small_val);
      default: s = SB'($urandom);
    endcase
    send_request(c, ch, s);
  endtask

  task automatic run_random(input int n, input int send_pct, input int stall_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
    repeat (n) random_request();
  endtask

  task automatic wait_idle();
    sample_valid <= 1'b0;
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_coefs(input int a0, input int a1, input int a2,
                           input int b1, input int b2, input int b3, input int b4);
    logic [hpf4_pkg::COEF_W-1:0] vals [hpf4_pkg::NUM_COEF];
    int i;
    wait_idle();
    vals[hpf4_pkg::REG_A0] = a0;
    vals[hpf4_pkg::REG_A1] = a1;
    vals[hpf4_pkg::REG_A2] = a2;
    vals[hpf4_pkg::REG_B1] = b1;
    vals[hpf4_pkg::REG_B2] = b2;
    vals[hpf4_pkg::REG_B3] = b3;
    vals[hpf4_pkg::REG_B4] = b4;
    for (i = 0; i < hpf4_pkg::NUM_COEF; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= hpf4_pkg::CFG_IDX_W'(i);
      cfg_data  <= vals[i];
      @(negedge clk);
    end
    // unused index, must leave the coefficients alone
    cfg_index <= hpf4_pkg::CFG_IDX_W'(hpf4_pkg::NUM_COEF);
    cfg_data  <= $urandom;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    rst            = 1'b1;
    cfg_we         = 1'b0;
    cfg_index      = hpf4_pkg::REG_A0;
    cfg_data       = '0;
    sample_valid   = 1'b0;
    cmd            = hpf4_pkg::CMD_FILTER;
    channel        = '0;
    sample_in      = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_left      = 0;
    last_ch        = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // coefficients still zero after reset
    send_request(hpf4_pkg::CMD_FILTER, 3'd0, SAMPLE_MAX);
    send_request(hpf4_pkg::CMD_FILTER, 3'd7, SAMPLE_MIN);

    // butterworth at a quarter of the sample rate
    set_coefs(12613916, -50455531, 75683364, 0, 65233573, 0, 2370822);
    send_request(hpf4_pkg::CMD_FILTER, 3'd0, SAMPLE_MAX);
    send_request(hpf4_pkg::CMD_FILTER, 3'd0, SAMPLE_MIN);
    send_request(hpf4_pkg::CMD_FILTER, 3'd0, SAMPLE_MAX);
    send_request(hpf4_pkg::CMD_FILTER, 3'd0, SAMPLE_MIN);
    send_request(hpf4_pkg::CMD_FILTER, 3'd0, SAMPLE_MAX);
    send_request(hpf4_pkg::CMD_FILTER, 3'd7, '1);
    send_request(hpf4_pkg::CMD_FILTER, 3'd7, SB'(1));
    send_request(hpf4_pkg::CMD_CLEAR, 3'd5, 24'h5A5A5A);
    send_request(hpf4_pkg::CMD_FILTER, 3'd0, SB'(1));
    send_request(hpf4_pkg::CMD_FILTER, 3'd7, '0);

    // extreme weights, drives both saturation limits
    set_coefs(COEF_MAX, COEF_MIN, COEF_MAX, COEF_MIN, COEF_MAX, COEF_MIN, COEF_MAX);
    send_request(hpf4_pkg::CMD_FILTER, 3'd3, SAMPLE_MAX);
    send_request(hpf4_pkg::CMD_FILTER, 3'd3, SAMPLE_MIN);
    send_request(hpf4_pkg::CMD_FILTER, 3'd3, SAMPLE_MAX);
    send_request(hpf4_pkg::CMD_FILTER, 3'd3, SAMPLE_MIN);
    send_request(hpf4_pkg::CMD_FILTER, 3'd3, SAMPLE_MAX);
    send_request(hpf4_pkg::CMD_FILTER, 3'd3, '0);
    send_request(hpf4_pkg::CMD_FILTER, 3'd4, SAMPLE_MIN);

    // butterworth at a tenth of the sample rate
    set_coefs(58095692, -232382769, 348574156, -318030653, 310578267, -141554788, 25149650);
    run_random(100, 0, 0);
    run_random(60, 88, 0);

    set_coefs($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    run_random(60, 0, 88);

    set_coefs(int'($urandom_range(1 << 27)) - (1 << 26),
              int'($urandom_range(1 << 27)) - (1 << 26),
              int'($urandom_range(1 << 27)) - (1 << 26),
              int'($urandom_range(1 << 25)) - (1 << 24),
              int'($urandom_range(1 << 25)) - (1 << 24),
              int'($urandom_range(1 << 25)) - (1 << 24),
              int'($urandom_range(1 << 25)) - (1 << 24));
    run_random(100, 7, 7);

    // long receiver hold-off while requests keep coming
    set_coefs(12613916, -50455531, 75683364, 0, 65233573, 0, 2370822);
    hold_left = 300;
    run_random(60, 0, 0);

    set_coefs(58095692, -232382769, 348574156, -318030653, 310578267, -141554788, 25149650);
    run_random(120, 7, 7);

    wait_idle();
    if (failures == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
